// File: design/ebt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebt_pkg
// Types and constants shared by the expiring blacklist table.
// ----------------------------------------------------------------------------
package ebt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_BITS      = 32;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int KEY_W         = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int CFG_W         = 32;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_DURATION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PURGE    = 1'b1;

	localparam logic KIND_MARK  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [31:0] DURATION_RESET = 32'd3600;
	localparam logic [15:0] PURGE_RESET    = 16'd100;

	typedef struct packed {
		logic        kind;
		logic [31:0] endpoint_key;
		logic [31:0] now_time;
	} ebt_req_t;

	typedef struct packed {
		logic is_listed;
		logic table_full;
	} ebt_rsp_t;

endpackage

// File: design/expiring_blacklist_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_blacklist_table_unit
// One item at a time; busy stays high from start through the single pass over
// the key and expiry memories, one entry per cycle, and the finish state.
// The pass purges expired entries when a purge is due and finds the key and
// the first free slot. Reset clears the valid bits, the operation counter and
// the scan and result registers; the memories and request registers are not reset.
// ----------------------------------------------------------------------------
module expiring_blacklist_table_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  ebt_pkg::ebt_req_t                req,
	output logic                             done,
	output ebt_pkg::ebt_rsp_t                rsp,
	input  logic                             cfg_we,
	input  logic [ebt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ebt_pkg::CFG_W-1:0]        cfg_data
);
	import ebt_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST, ST_FINISH} state_t;

	state_t                   state_q;
	logic [31:0]              dur_q;
	logic [15:0]              pint_q;
	logic [15:0]              opcnt_q;
	logic [15:0]              opcnt_inc;
	logic                     kind_q;
	logic [KEY_W-1:0]         key_q;
	logic [31:0]              now_q;
	logic                     purge_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic                     pend_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic                     found_q;
	logic [IDX_W-1:0]         found_idx_q;
	logic [31:0]              found_exp_q;
	logic                     free_q;
	logic [IDX_W-1:0]         free_idx_q;

	logic [KEY_W-1:0]         key_mem [TABLE_ENTRIES];
	logic [31:0]              exp_mem [TABLE_ENTRIES];
	logic [KEY_W-1:0]         rd_key;
	logic [31:0]              rd_exp;

	logic                     expired_s1;
	logic                     live_s1;
	logic                     fin;
	logic                     key_we;
	logic                     exp_we;
	logic [IDX_W-1:0]         wr_idx;
	logic [31:0]              new_exp;

	assign busy      = (state_q != ST_IDLE);
	assign opcnt_inc = opcnt_q + 16'd1;

	assign expired_s1 = rd_exp < now_q;
	assign live_s1    = valid_q[idx_s1] && !(purge_q && expired_s1);

	assign fin     = (state_q == ST_FINISH);
	assign new_exp = now_q + dur_q;
	assign key_we  = fin && (kind_q == KIND_MARK) && !found_q && free_q;
	assign exp_we  = fin && (kind_q == KIND_MARK) &&
		(found_q ? (found_exp_q < now_q) : free_q);
	assign wr_idx  = found_q ? found_idx_q : free_idx_q;

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_idx] <= key_q;
		end
		if (exp_we) begin
			exp_mem[wr_idx] <= new_exp;
		end
		rd_key <= key_mem[rd_idx_q];
		rd_exp <= exp_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= DURATION_RESET;
			pint_q <= PURGE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DURATION: dur_q <= cfg_data[31:0];
				REG_PURGE:    pint_q <= cfg_data[15:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q <= req.kind;
			key_q <= req.endpoint_key[KEY_W-1:0];
			now_q <= req.now_time;
			purge_q <= (opcnt_inc > pint_q);
		end
		idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			opcnt_q <= '0;
			rd_idx_q <= '0;
			pend_s1 <= 1'b0;
			valid_q <= '0;
			found_q <= 1'b0;
			found_idx_q <= '0;
			found_exp_q <= '0;
			free_q <= 1'b0;
			free_idx_q <= '0;
			done <= 1'b0;
			rsp <= '0;
		end else begin
			done <= 1'b0;
			if (pend_s1) begin
				if (purge_q && expired_s1) begin
					valid_q[idx_s1] <= 1'b0;
				end
				if (live_s1 && (rd_key == key_q) && !found_q) begin
					found_q <= 1'b1;
					found_idx_q <= idx_s1;
					found_exp_q <= rd_exp;
				end
				if (!live_s1 && !free_q) begin
					free_q <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						opcnt_q <= (opcnt_inc > pint_q) ? 16'd0 : opcnt_inc;
						rd_idx_q <= '0;
						found_q <= 1'b0;
						free_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_s1 <= 1'b1;
					if (rd_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_LAST;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_LAST: begin
					pend_s1 <= 1'b0;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (key_we) begin
						valid_q[wr_idx] <= 1'b1;
					end
					done <= 1'b1;
					rsp.is_listed <= (kind_q == KIND_QUERY) && found_q &&
						(found_exp_q >= now_q);
					rsp.table_full <= (kind_q == KIND_MARK) && !found_q && !free_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
